/* rtl/core/sil_pkg.sv */
package sil_pkg;

    localparam int STORE_DEPTH = 32;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int CNT_W       = $clog2(STORE_DEPTH + 1);

    localparam logic [1:0] MODE_INSERT = 2'd0;
    localparam logic [1:0] MODE_READ   = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    typedef enum logic
    {
        RD_CUR,
        RD_PREV
    } rd_sel_t;

    typedef enum logic
    {
        WR_SHIFT,
        WR_PLACE
    } wr_sel_t;

    typedef enum logic [1:0]
    {
        OUT_INSERT,
        OUT_EMPTY,
        OUT_ENTRY
    } out_sel_t;

    typedef struct packed
    {
        logic     start;
        logic     rd_en;
        rd_sel_t  rd_sel;
        logic     wr_en;
        wr_sel_t  wr_sel;
        logic     hit;
        logic     idx_inc;
        logic     idx_dec;
        logic     decide;
        logic     count_inc;
        logic     out_load;
        out_sel_t out_sel;
    } cmd_t;

    typedef struct packed
    {
        logic       count_zero;
        logic       full;
        logic       ge;
        logic       idx_last;
        logic       slot_is_count;
        logic       prev_is_slot;
        logic       out_free;
    } sts_t;

endpackage

/* rtl/core/sil_in_if.sv */
interface sil_in_if;
    import sil_pkg::*;

    logic                     valid;
    logic                     ready;
    logic [1:0]               mode;
    logic signed [DATA_W-1:0] value;

    modport source (output valid, output mode, output value, input ready);
    modport sink (input valid, input mode, input value, output ready);
endinterface

/* rtl/core/sil_out_if.sv */
interface sil_out_if;
    import sil_pkg::*;

    logic                     valid;
    logic                     ready;
    logic signed [DATA_W-1:0] out_value;
    logic                     is_last;
    logic                     found_equal;
    logic                     overflow;
    logic                     empty_res;

    modport source
    (
        output valid, output out_value, output is_last, output found_equal,
        output overflow, output empty_res, input ready
    );
    modport sink
    (
        input valid, input out_value, input is_last, input found_equal,
        input overflow, input empty_res, output ready
    );
endinterface

/* rtl/core/sil_ram.sv */
module sil_ram
#(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
)
(
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;
endmodule

/* rtl/core/sil_dp.sv */
module sil_dp
    import sil_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic [1:0]               in_mode,
    input  logic signed [DATA_W-1:0] in_value,
    input  cmd_t                     cmd,
    output sts_t                     sts,
    sil_out_if.source                out
);
    logic signed [DATA_W-1:0] value_reg;
    logic [CNT_W-1:0]         idx_reg;
    logic [CNT_W-1:0]         slot_reg;
    logic [CNT_W-1:0]         count_reg;
    logic                     found_reg;
    logic                     ovf_reg;

    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [DATA_W-1:0] out_value_reg;
    logic                     out_last_reg;
    logic                     out_found_reg;
    logic                     out_ovf_reg;
    logic                     out_empty_reg;

    logic [CNT_W-1:0]  idx_prev;
    logic [CNT_W-1:0]  idx_succ;
    logic [ADDR_W-1:0] raddr;
    logic [ADDR_W-1:0] waddr;
    logic [DATA_W-1:0] wdata;
    logic [DATA_W-1:0] rdata;

    assign idx_prev = idx_reg - CNT_W'(1);
    assign idx_succ = idx_reg + CNT_W'(1);

    always_comb
    begin
        case (cmd.rd_sel)
            RD_CUR:  raddr = idx_reg[ADDR_W-1:0];
            RD_PREV: raddr = idx_prev[ADDR_W-1:0];
            default: raddr = idx_reg[ADDR_W-1:0];
        endcase
        case (cmd.wr_sel)
            WR_SHIFT:
            begin
                waddr = idx_reg[ADDR_W-1:0];
                wdata = rdata;
            end
            WR_PLACE:
            begin
                waddr = slot_reg[ADDR_W-1:0];
                wdata = value_reg;
            end
            default:
            begin
                waddr = idx_reg[ADDR_W-1:0];
                wdata = rdata;
            end
        endcase
    end

    sil_ram
    #(
        .WIDTH (DATA_W),
        .DEPTH (STORE_DEPTH)
    )
    u_ram
    (
        .clk   (clk),
        .we    (cmd.wr_en),
        .waddr (waddr),
        .wdata (wdata),
        .re    (cmd.rd_en),
        .raddr (raddr),
        .rdata (rdata)
    );

    assign sts.count_zero    = (count_reg == '0);
    assign sts.full          = (count_reg == CNT_W'(STORE_DEPTH));
    assign sts.ge            = ($signed(rdata) >= value_reg);
    assign sts.idx_last      = (idx_succ == count_reg);
    assign sts.slot_is_count = (slot_reg == count_reg);
    assign sts.prev_is_slot  = (idx_prev == slot_reg);
    assign sts.out_free      = !out_valid_reg || out.ready;

    // A clear acts in its accept cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else if (cmd.start && (in_mode == MODE_CLEAR))
        begin
            count_reg <= '0;
        end
        else if (cmd.count_inc)
        begin
            count_reg <= count_reg + CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.start)
        begin
            value_reg <= in_value;
            idx_reg   <= '0;
            slot_reg  <= count_reg;
            found_reg <= 1'b0;
        end
        else
        begin
            if (cmd.hit)
            begin
                slot_reg  <= idx_reg;
                found_reg <= (rdata == value_reg);
            end
            if (cmd.decide)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_inc)
            begin
                idx_reg <= idx_succ;
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_prev;
            end
        end
        if (cmd.decide)
        begin
            ovf_reg <= sts.full;
        end
    end

    always_comb
    begin
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            case (cmd.out_sel)
                OUT_INSERT:
                begin
                    out_value_reg <= '0;
                    out_last_reg  <= 1'b1;
                    out_found_reg <= found_reg;
                    out_ovf_reg   <= ovf_reg;
                    out_empty_reg <= 1'b0;
                end
                OUT_EMPTY:
                begin
                    out_value_reg <= '0;
                    out_last_reg  <= 1'b1;
                    out_found_reg <= 1'b0;
                    out_ovf_reg   <= 1'b0;
                    out_empty_reg <= 1'b1;
                end
                OUT_ENTRY:
                begin
                    out_value_reg <= $signed(rdata);
                    out_last_reg  <= sts.idx_last;
                    out_found_reg <= 1'b0;
                    out_ovf_reg   <= 1'b0;
                    out_empty_reg <= 1'b0;
                end
                default:
                begin
                    out_value_reg <= '0;
                    out_last_reg  <= 1'b1;
                    out_found_reg <= 1'b0;
                    out_ovf_reg   <= 1'b0;
                    out_empty_reg <= 1'b0;
                end
            endcase
        end
    end

    assign out.valid       = out_valid_reg;
    assign out.out_value   = out_value_reg;
    assign out.is_last     = out_last_reg;
    assign out.found_equal = out_found_reg;
    assign out.overflow    = out_ovf_reg;
    assign out.empty_res   = out_empty_reg;
endmodule

/* rtl/core/sil_ctrl.sv */
module sil_ctrl
    import sil_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    input  logic [1:0] in_mode,
    output logic       in_ready,
    input  sts_t       sts,
    output cmd_t       cmd
);
    typedef enum logic [10:0]
    {
        ST_IDLE      = 11'b000_0000_0001,
        ST_SRCH_RD   = 11'b000_0000_0010,
        ST_SRCH_CMP  = 11'b000_0000_0100,
        ST_DECIDE    = 11'b000_0000_1000,
        ST_SHIFT_RD  = 11'b000_0001_0000,
        ST_SHIFT_WR  = 11'b000_0010_0000,
        ST_PLACE     = 11'b000_0100_0000,
        ST_RESULT    = 11'b000_1000_0000,
        ST_EMPTY_OUT = 11'b001_0000_0000,
        ST_RD_RD     = 11'b010_0000_0000,
        ST_RD_OUT    = 11'b100_0000_0000
    } state_t;

    state_t state_reg;
    state_t state_next;

    assign in_ready = (state_reg == ST_IDLE);

    always_comb
    begin
        state_next    = state_reg;
        cmd           = '0;
        cmd.rd_sel    = RD_CUR;
        cmd.wr_sel    = WR_SHIFT;
        cmd.out_sel   = OUT_INSERT;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.start = 1'b1;
                    if (in_mode == MODE_INSERT)
                    begin
                        state_next = sts.count_zero ? ST_DECIDE : ST_SRCH_RD;
                    end
                    else if (in_mode == MODE_READ)
                    begin
                        state_next = sts.count_zero ? ST_EMPTY_OUT : ST_RD_RD;
                    end
                end
            end
            ST_SRCH_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_SRCH_CMP;
            end
            ST_SRCH_CMP:
            begin
                if (sts.ge)
                begin
                    cmd.hit    = 1'b1;
                    state_next = ST_DECIDE;
                end
                else if (sts.idx_last)
                begin
                    state_next = ST_DECIDE;
                end
                else
                begin
                    cmd.idx_inc = 1'b1;
                    state_next  = ST_SRCH_RD;
                end
            end
            ST_DECIDE:
            begin
                cmd.decide = 1'b1;
                if (sts.full)
                begin
                    state_next = ST_RESULT;
                end
                else if (sts.slot_is_count)
                begin
                    state_next = ST_PLACE;
                end
                else
                begin
                    state_next = ST_SHIFT_RD;
                end
            end
            ST_SHIFT_RD:
            begin
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = RD_PREV;
                state_next = ST_SHIFT_WR;
            end
            ST_SHIFT_WR:
            begin
                cmd.wr_en   = 1'b1;
                cmd.wr_sel  = WR_SHIFT;
                cmd.idx_dec = 1'b1;
                state_next  = sts.prev_is_slot ? ST_PLACE : ST_SHIFT_RD;
            end
            ST_PLACE:
            begin
                cmd.wr_en     = 1'b1;
                cmd.wr_sel    = WR_PLACE;
                cmd.count_inc = 1'b1;
                state_next    = ST_RESULT;
            end
            ST_RESULT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_INSERT;
                    state_next   = ST_IDLE;
                end
            end
            ST_EMPTY_OUT:
            begin
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_EMPTY;
                    state_next   = ST_IDLE;
                end
            end
            ST_RD_RD:
            begin
                cmd.rd_en  = 1'b1;
                state_next = ST_RD_OUT;
            end
            ST_RD_OUT:
            begin
                // The RAM read register holds its word until the next read.
                if (sts.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = OUT_ENTRY;
                    if (sts.idx_last)
                    begin
                        state_next = ST_IDLE;
                    end
                    else
                    begin
                        cmd.idx_inc = 1'b1;
                        state_next  = ST_RD_RD;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end
endmodule

/* rtl/core/sorted_insert_list_top.sv */
// Sorted insert list: keeps up to STORE_DEPTH signed 32-bit values in ascending
// order in a single-port-read RAM. An insert item (mode 0) walks the entries
// from the smallest up to the first one not below its value, or to the end;
// unless the store is full it then moves every entry from that slot on up one
// slot, reading each from the RAM before writing it back, places the value and
// returns one result with found_equal and overflow. A full store skips the move.
// A read-out item (mode 1) emits the entries in order, one per RAM read, and
// flags the last one, or a single empty_res result when nothing is stored.
// A clear item (mode 2) empties the store and returns nothing, as does mode 3.
// One item is worked on at a time; req.ready is high only between items, and a
// finished result waits in the output register.
module sorted_insert_list_top
    import sil_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    sil_in_if.sink    req,
    sil_out_if.source rsp
);
    cmd_t cmd;
    sts_t sts;
    logic in_ready;

    assign req.ready = in_ready;

    sil_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_mode  (req.mode),
        .in_ready (in_ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    sil_dp u_dp
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_mode  (req.mode),
        .in_value (req.value),
        .cmd      (cmd),
        .sts      (sts),
        .out      (rsp)
    );
endmodule

/* rtl/core/sil_chk.sv */
module sil_chk
    import sil_pkg::*;
(
    input logic                     clk,
    input logic                     rst_n,
    input logic                     req_valid,
    input logic                     req_ready,
    input logic [1:0]               req_mode,
    input logic                     rsp_valid,
    input logic                     rsp_ready,
    input logic signed [DATA_W-1:0] rsp_out_value,
    input logic                     rsp_is_last,
    input logic                     rsp_found_equal,
    input logic                     rsp_overflow,
    input logic                     rsp_empty_res
);
    // A result that is still waiting must not change.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_out_value)
            && $stable(rsp_is_last))
    else $error("result changed while stalled");

    // An insert or read-out item holds req.ready low in the cycle after it is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        req_valid && req_ready && (req_mode == MODE_INSERT || req_mode == MODE_READ)
            |=> !req_ready)
    else $error("new item taken right after insert or read out");

    // While a read-out still has entries to emit, no new item is taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_is_last |-> !req_ready)
    else $error("item taken in the middle of a read out");

    // Insert and empty results are single results with a zero value.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && (rsp_found_equal || rsp_overflow || rsp_empty_res)
            |-> rsp_is_last && (rsp_out_value == '0)
                && !(rsp_empty_res && (rsp_found_equal || rsp_overflow)))
    else $error("malformed insert or empty result");
endmodule

bind sorted_insert_list_top sil_chk u_chk
(
    .clk             (clk),
    .rst_n           (rst_n),
    .req_valid       (req.valid),
    .req_ready       (req.ready),
    .req_mode        (req.mode),
    .rsp_valid       (rsp.valid),
    .rsp_ready       (rsp.ready),
    .rsp_out_value   (rsp.out_value),
    .rsp_is_last     (rsp.is_last),
    .rsp_found_equal (rsp.found_equal),
    .rsp_overflow    (rsp.overflow),
    .rsp_empty_res   (rsp.empty_res)
);

/* sim/sorted_insert_list_top_test.sv */
module sorted_insert_list_top_test;
    import sil_pkg::*;

    // Mode 3 has no meaning; the block must ignore it.
    localparam logic [1:0] MODE_UNUSED = 2'd3;
    localparam int TARGET_ITEMS = 400;
    localparam int DRAIN_CYCLES = 4 * STORE_DEPTH + 64;

    typedef struct packed
    {
        logic [1:0]               mode;
        logic signed [DATA_W-1:0] value;
    } list_item_t;

    typedef struct packed
    {
        logic signed [DATA_W-1:0] out_value;
        logic                     is_last;
        logic                     found_equal;
        logic                     overflow;
        logic                     empty_res;
    } list_result_t;

    logic clk;
    logic rst_n;

    sil_in_if  req_if ();
    sil_out_if rsp_if ();

    sorted_insert_list_top dut
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_if),
        .rsp   (rsp_if)
    );

    list_item_t   pending_items[$];
    list_result_t expected_results[$];
    int           errors;
    logic         idle_ok;

    // Shadow copy of the sorted store.
    logic signed [DATA_W-1:0] model_entries[STORE_DEPTH];
    int                       model_count;

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic list_result_t make_result(logic signed [DATA_W-1:0] v, logic last,
                                                 logic found, logic ovf, logic empty);
        list_result_t r;
        r.out_value   = v;
        r.is_last     = last;
        r.found_equal = found;
        r.overflow    = ovf;
        r.empty_res   = empty;
        return r;
    endfunction

    task automatic predict_list_step(list_item_t item);
        int   slot;
        logic found;
        slot  = model_count;
        found = 1'b0;
        case (item.mode)
            MODE_INSERT:
            begin
                for (int i = 0; i < model_count; i++)
                begin
                    if (model_entries[i] >= item.value)
                    begin
                        slot  = i;
                        found = (model_entries[i] == item.value);
                        break;
                    end
                end
                if (model_count >= STORE_DEPTH)
                begin
                    expected_results.push_back(make_result('0, 1'b1, found, 1'b1, 1'b0));
                end
                else
                begin
                    for (int i = model_count; i > slot; i--)
                        model_entries[i] = model_entries[i - 1];
                    model_entries[slot] = item.value;
                    model_count++;
                    expected_results.push_back(make_result('0, 1'b1, found, 1'b0, 1'b0));
                end
            end
            MODE_READ:
            begin
                if (model_count == 0)
                    expected_results.push_back(make_result('0, 1'b1, 1'b0, 1'b0, 1'b1));
                else
                    for (int i = 0; i < model_count; i++)
                        expected_results.push_back(make_result(model_entries[i],
                            (i == model_count - 1), 1'b0, 1'b0, 1'b0));
            end
            MODE_CLEAR:
                model_count = 0;
            default:
                ;
        endcase
    endtask

    task automatic check_field(string name, logic [DATA_W-1:0] exp_v, logic [DATA_W-1:0] act_v);
        if (exp_v !== act_v)
        begin
            errors++;
            if (errors <= 40)
                $display("%0t: %s mismatch, expected %0h, got %0h", $time, name, exp_v, act_v);
        end
    endtask

    function automatic logic signed [DATA_W-1:0] pick_value();
        logic signed [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0: v = {1'b0, {(DATA_W-1){1'b1}}};
            1: v = {1'b1, {(DATA_W-1){1'b0}}};
            2, 3, 4: v = $signed($urandom_range(0, 8)) - 4;
            5: v = {1'($urandom_range(0, 1)), (DATA_W-1)'($urandom_range(0, 3))};
            default: v = $urandom();
        endcase
        return v;
    endfunction

    task automatic add_item(logic [1:0] m, logic signed [DATA_W-1:0] v);
        list_item_t it;
        it.mode  = m;
        it.value = v;
        pending_items.push_back(it);
    endtask

    // Driver: offers the pending items one at a time, with random gaps.
    list_item_t offered_item;
    int         drv_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            req_if.valid <= 1'b0;
            req_if.mode  <= MODE_INSERT;
            req_if.value <= '0;
            idle_ok      <= 1'b0;
            drv_gap      = 0;
        end
        else
        begin
            // Long stretches run without stalls, and the tail of the run has none.
            idle_ok <= (pending_items.size() > 60) && ((pending_items.size() / 50) % 3 != 0);
            if (req_if.valid && req_if.ready)
                predict_list_step(offered_item);
            if (!req_if.valid || req_if.ready)
            begin
                if (drv_gap > 0)
                begin
                    drv_gap--;
                    req_if.valid <= 1'b0;
                end
                else if (pending_items.size() == 0)
                begin
                    req_if.valid <= 1'b0;
                end
                else if (idle_ok && $urandom_range(0, 5) == 0)
                begin
                    drv_gap = $urandom_range(1, 19) - 1;
                    req_if.valid <= 1'b0;
                end
                else
                begin
                    offered_item = pending_items.pop_front();
                    req_if.valid <= 1'b1;
                    req_if.mode  <= offered_item.mode;
                    req_if.value <= offered_item.value;
                end
            end
        end
    end

    // Monitor: takes results with a randomly stalling ready and checks them in order.
    list_result_t seen_result;
    list_result_t want_result;
    int           rdy_gap;

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rsp_if.ready <= 1'b0;
            rdy_gap      = 0;
        end
        else
        begin
            if (rsp_if.valid && rsp_if.ready)
            begin
                seen_result = make_result(rsp_if.out_value, rsp_if.is_last,
                                          rsp_if.found_equal, rsp_if.overflow,
                                          rsp_if.empty_res);
                if (expected_results.size() == 0)
                begin
                    errors++;
                    $display("%0t: unexpected result, expected none, got %0h", $time,
                             seen_result);
                end
                else
                begin
                    want_result = expected_results.pop_front();
                    check_field("out_value", want_result.out_value, seen_result.out_value);
                    check_field("is_last", DATA_W'(want_result.is_last),
                                DATA_W'(seen_result.is_last));
                    check_field("found_equal", DATA_W'(want_result.found_equal),
                                DATA_W'(seen_result.found_equal));
                    check_field("overflow", DATA_W'(want_result.overflow),
                                DATA_W'(seen_result.overflow));
                    check_field("empty_res", DATA_W'(want_result.empty_res),
                                DATA_W'(seen_result.empty_res));
                end
            end
            if (rdy_gap > 0)
            begin
                rdy_gap--;
                rsp_if.ready <= 1'b0;
            end
            else if (idle_ok && $urandom_range(0, 5) == 0)
            begin
                rdy_gap = $urandom_range(1, 19) - 1;
                rsp_if.ready <= 1'b0;
            end
            else
            begin
                rsp_if.ready <= 1'b1;
            end
        end
    end

    initial
    begin
        int counted;
        int run_len;
        clk          = 1'b0;
        rst_n        = 1'b0;
        errors       = 0;
        model_count  = 0;
        idle_ok      = 1'b0;
        req_if.valid = 1'b0;
        req_if.mode  = MODE_INSERT;
        req_if.value = '0;
        rsp_if.ready = 1'b0;
        counted      = 0;

        // Directed part: empty store, extremes, duplicates at both ends, ignored modes.
        add_item(MODE_READ, '0);
        add_item(MODE_CLEAR, '1);
        add_item(MODE_UNUSED, '1);
        add_item(MODE_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
        add_item(MODE_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
        add_item(MODE_INSERT, 0);
        add_item(MODE_INSERT, 0);
        add_item(MODE_INSERT, -1);
        add_item(MODE_INSERT, 1);
        add_item(MODE_INSERT, {1'b0, {(DATA_W-1){1'b1}}});
        add_item(MODE_INSERT, {1'b1, {(DATA_W-1){1'b0}}});
        add_item(MODE_READ, '1);
        add_item(MODE_UNUSED, 0);
        add_item(MODE_READ, 0);
        add_item(MODE_CLEAR, 0);
        add_item(MODE_READ, 0);
        add_item(MODE_INSERT, 5);
        add_item(MODE_READ, 0);

        // Random sessions: mostly clear, a run of inserts, then a read-out. The first
        // session and some later ones run close to or past the store's capacity.
        while (counted < TARGET_ITEMS)
        begin
            if (counted == 0 || $urandom_range(0, 4) != 0)
                add_item(MODE_CLEAR, $urandom());
            if (counted == 0 || $urandom_range(0, 4) == 0)
                run_len = $urandom_range(STORE_DEPTH - 2, STORE_DEPTH + 8);
            else
                run_len = $urandom_range(0, 12);
            for (int k = 0; k < run_len; k++)
            begin
                add_item(MODE_INSERT, pick_value());
                counted++;
                if ($urandom_range(0, 9) == 0)
                begin
                    add_item(MODE_READ, $urandom());
                    counted++;
                end
                if ($urandom_range(0, 29) == 0)
                    add_item(MODE_UNUSED, $urandom());
            end
            add_item(MODE_READ, $urandom());
            counted++;
        end

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        while (pending_items.size() != 0 || req_if.valid || expected_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin
        #4000000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule
